// ===== rtl/bswf_pkg.sv =====
// Shared constants, types and helpers for the byte-stuffed word frame link.
// Used by bswf_rx, bswf_tx and the top level; no dependencies.
package bswf_pkg;

  localparam logic [7:0] SOF_BYTE  = 8'h02;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // received payload length, 1 to 8
  localparam int PAYLOAD_BYTES = 2;
  localparam int PIDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [PIDX_W-1:0] PIDX_LAST = PIDX_W'(PAYLOAD_BYTES - 1);

  // reply frame: head, up to four stuffed word bytes, checksum
  localparam int TXQ_DEPTH = 5;
  localparam int TXQ_CNT_W = 3;

  typedef logic [7:0] byte_t;
  typedef byte_t payload_t [PAYLOAD_BYTES];

  // reply request from the deframer to the reply builder
  typedef struct packed {
    logic        req;
    logic [15:0] word;
  } reply_t;

  // big-endian fold of the payload, low 16 bits kept
  function automatic logic [15:0] pack_word(input payload_t pl);
    logic [15:0] w;
    w = 16'h0000;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      w = {w[7:0], pl[i]};
    end
    return w;
  endfunction

endpackage

// ===== rtl/bswf_rx.sv =====
// Deframer: parses head, escaped payload and checksum, keeps the stored word.
// Depends on bswf_pkg.
module bswf_rx
  import bswf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   accept,
  input  byte_t  rx_byte,
  output reply_t reply
);

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [PIDX_W-1:0] idx_r, idx_nxt;
  logic              esc_r, esc_nxt;
  byte_t             sum_r, sum_nxt;
  payload_t          payload_r, payload_nxt;
  logic [15:0]       word_r, word_nxt;
  logic              req;
  byte_t             take_val;
  logic              take;

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    esc_nxt     = esc_r;
    sum_nxt     = sum_r;
    payload_nxt = payload_r;
    word_nxt    = word_r;
    req         = 1'b0;
    take        = 1'b0;
    take_val    = rx_byte;
    unique case (phase_r)
      PH_PAYLOAD: begin
        sum_nxt = sum_r + rx_byte;
        if (esc_r) begin
          esc_nxt  = 1'b0;
          take     = 1'b1;
          take_val = rx_byte ^ ESC_XOR;
        end else if (rx_byte == ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      PH_CHECK: begin
        if (rx_byte == sum_r) begin
          word_nxt = pack_word(payload_r);
        end
        phase_nxt = PH_WAIT;
        idx_nxt   = '0;
        esc_nxt   = 1'b0;
        sum_nxt   = '0;
        req       = 1'b1;
      end
      default: begin
        // unused phase code behaves as waiting for head
        if (rx_byte == SOF_BYTE) begin
          phase_nxt = PH_PAYLOAD;
          idx_nxt   = '0;
          esc_nxt   = 1'b0;
          sum_nxt   = '0;
        end else begin
          phase_nxt = PH_WAIT;
          req       = 1'b1;
        end
      end
    endcase
    if (take) begin
      payload_nxt[idx_r] = take_val;
      if (idx_r == PIDX_LAST) begin
        phase_nxt = PH_CHECK;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  assign reply.req  = accept & req;
  assign reply.word = word_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      idx_r   <= '0;
      esc_r   <= 1'b0;
      sum_r   <= '0;
      word_r  <= '0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        payload_r[i] <= '0;
      end
    end else if (accept) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      esc_r     <= esc_nxt;
      sum_r     <= sum_nxt;
      word_r    <= word_nxt;
      payload_r <= payload_nxt;
    end
  end

endmodule

// ===== rtl/bswf_tx.sv =====
// Reply builder: stuffs the word into a frame and sends it one beat a cycle while out_ready is high.
// Depends on bswf_pkg.
module bswf_tx
  import bswf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  reply_t reply,
  output logic   start_ready,
  output byte_t  out_data,
  output logic   out_last,
  output logic   out_valid,
  input  logic   out_ready
);

  byte_t                data_r;
  logic                 last_r;
  logic                 valid_r;
  byte_t                q_r [TXQ_DEPTH];
  logic [TXQ_CNT_W-1:0] rem_r;

  byte_t                q_new [TXQ_DEPTH];
  logic [TXQ_CNT_W-1:0] rem_new;
  byte_t                hi, lo, hi_x, lo_x, sum;
  logic                 esc_hi, esc_lo;
  logic                 pop;

  always_comb begin
    hi     = reply.word[15:8];
    lo     = reply.word[7:0];
    hi_x   = hi ^ ESC_XOR;
    lo_x   = lo ^ ESC_XOR;
    esc_hi = (hi == ESC_BYTE) || (hi == SOF_BYTE);
    esc_lo = (lo == ESC_BYTE) || (lo == SOF_BYTE);
    sum    = (esc_hi ? byte_t'(ESC_BYTE + hi_x) : hi)
           + (esc_lo ? byte_t'(ESC_BYTE + lo_x) : lo);
    for (int i = 0; i < TXQ_DEPTH; i++) begin
      q_new[i] = '0;
    end
    unique case ({esc_hi, esc_lo})
      2'b00: begin
        q_new[0] = hi;       q_new[1] = lo;       q_new[2] = sum;
        rem_new  = TXQ_CNT_W'(3);
      end
      2'b01: begin
        q_new[0] = hi;       q_new[1] = ESC_BYTE; q_new[2] = lo_x;
        q_new[3] = sum;
        rem_new  = TXQ_CNT_W'(4);
      end
      2'b10: begin
        q_new[0] = ESC_BYTE; q_new[1] = hi_x;     q_new[2] = lo;
        q_new[3] = sum;
        rem_new  = TXQ_CNT_W'(4);
      end
      default: begin
        q_new[0] = ESC_BYTE; q_new[1] = hi_x;     q_new[2] = ESC_BYTE;
        q_new[3] = lo_x;     q_new[4] = sum;
        rem_new  = TXQ_CNT_W'(5);
      end
    endcase
  end

  // free for a new frame when nothing is held or the final beat leaves now
  assign start_ready = !valid_r || (out_ready && (rem_r == '0));
  assign pop         = valid_r && out_ready;

  assign out_data  = data_r;
  assign out_last  = last_r;
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rem_r   <= '0;
    end else if (reply.req) begin
      valid_r <= 1'b1;
      data_r  <= SOF_BYTE;
      last_r  <= 1'b0;
      q_r     <= q_new;
      rem_r   <= rem_new;
    end else if (pop) begin
      if (rem_r == '0) begin
        valid_r <= 1'b0;
      end else begin
        // advance the queue by one beat
        data_r <= q_r[0];
        last_r <= (rem_r == TXQ_CNT_W'(1));
        for (int i = 0; i < TXQ_DEPTH - 1; i++) begin
          q_r[i] <= q_r[i+1];
        end
        rem_r <= rem_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/byte_stuffed_word_frame_link_core.sv =====
// Top level of the byte-stuffed word frame link.
// Depends on bswf_pkg, bswf_rx and bswf_tx.
//
// Use:
//   in_*  : received bytes, one beat per byte (in_tdata = rx_byte).
//   out_* : reply frame bytes, one beat per byte; out_tlast marks the
//           checksum beat that ends a reply frame.
//   A head byte 0x02 opens a frame of two (escaped) payload bytes and a
//   checksum; a matching checksum updates the stored word. A finished frame,
//   or a non-head byte while waiting, triggers a reply: head, stuffed
//   high and low byte of the stored word, additive checksum.
// Reply: the first reply beat is registered and on the output in the cycle after
//   the triggering byte is accepted.
// Throughput: bytes that cause no reply are taken one per cycle while no
//   reply is in flight. A reply is 4 to 6 beats, one per cycle from the
//   output register while out_tready is high; the next input beat is
//   taken in the cycle the last reply beat leaves, so a new reply-causing
//   byte is not taken before the last reply is through.
// Reset: rst_n low clears the parser to waiting for head, the stored word
//   to zero and drops any reply in progress.
// Stall: while out_tready is low the current beat holds and in_tready stays
//   low once a reply is in flight.
module byte_stuffed_word_frame_link_core
  import bswf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] tx_byte
  output logic       out_tlast   // frame_end
);

  logic   in_accept;
  logic   start_ready;
  reply_t reply;

  assign in_tready = start_ready;
  assign in_accept = in_tvalid && start_ready;

  bswf_rx u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .rx_byte (in_tdata),
    .reply   (reply)
  );

  bswf_tx u_tx (
    .clk         (clk),
    .rst_n       (rst_n),
    .reply       (reply),
    .start_ready (start_ready),
    .out_data    (out_tdata),
    .out_last    (out_tlast),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready)
  );

endmodule
